// File: src/idiv_pkg.sv
// Shared types and constants for the 32-bit integer divider.
// No dependencies; imported by every module of the divider.
package idiv_pkg;

    localparam int unsigned DATA_W = 32;

    localparam logic [DATA_W-1:0] ALL_ONES  = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] NEG_LIMIT = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] POS_LIMIT = {1'b0, {(DATA_W-1){1'b1}}};

    // Division mode carried on the cmd field
    typedef enum logic {
        CMD_UNSIGNED = 1'b0,
        CMD_SIGNED   = 1'b1
    } div_cmd_t;

    // Bookkeeping that rides along with each beat to the output stage
    typedef struct packed {
        logic sgn;      // signed divide
        logic q_neg;    // negate quotient at the end
        logic r_neg;    // negate remainder at the end (numerator negative)
        logic dz;       // divisor was zero
        logic nz;       // numerator was zero
    } div_flags_t;

    // Data held by one cell of the divide chain
    typedef struct packed {
        logic [DATA_W-1:0] rem;   // partial remainder
        logic [DATA_W-1:0] quo;   // numerator bits shifting out, quotient bits shifting in
        logic [DATA_W-1:0] den;   // magnitude of the divisor
        div_flags_t        flags;
    } div_stage_t;

endpackage

// File: src/idiv_pre.sv
// Input stage of the divider: takes magnitudes of the operands and sets sign flags.
// Depends on idiv_pkg.
module idiv_pre import idiv_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic              cmd,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              out_valid,
    output div_stage_t        out_stage
);

    logic       valid_reg;
    logic       valid_next;
    div_stage_t stage_reg;
    div_stage_t stage_next;
    logic       num_neg;
    logic       den_neg;

    // Work out magnitudes and the fix-up flags
    always_comb begin
        num_neg = (cmd == CMD_SIGNED) && dividend[DATA_W-1];
        den_neg = (cmd == CMD_SIGNED) && divisor[DATA_W-1];
        stage_next.rem         = '0;
        stage_next.quo         = num_neg ? (~dividend + DATA_W'(1)) : dividend;
        stage_next.den         = den_neg ? (~divisor + DATA_W'(1)) : divisor;
        stage_next.flags.sgn   = (cmd == CMD_SIGNED);
        stage_next.flags.q_neg = num_neg ^ den_neg;
        stage_next.flags.r_neg = num_neg;
        stage_next.flags.dz    = (divisor == '0);
        stage_next.flags.nz    = (dividend == '0);
        valid_next             = in_valid;
    end

    // Hold control under reset, advance on enable
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// File: src/idiv_cell.sv
// One restoring-division cell: produces one quotient bit per beat.
// Depends on idiv_pkg.
module idiv_cell import idiv_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_valid,
    input  div_stage_t in_stage,
    output logic       out_valid,
    output div_stage_t out_stage
);

    logic              valid_reg;
    div_stage_t        stage_reg;
    div_stage_t        stage_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              fits;

    // Shift in the next numerator bit and try subtracting the divisor
    always_comb begin
        trial      = {in_stage.rem, in_stage.quo[DATA_W-1]};
        diff       = trial - {1'b0, in_stage.den};
        fits       = !diff[DATA_W];
        stage_next = in_stage;
        stage_next.rem = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        stage_next.quo = {in_stage.quo[DATA_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// File: src/idiv_post.sv
// Output stage of the divider: restores signs, applies divide-by-zero values,
// and holds the result beat. Depends on idiv_pkg.
module idiv_post import idiv_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  div_stage_t        in_stage,
    output logic              out_valid,
    output logic [DATA_W-1:0] quot,
    output logic [DATA_W-1:0] rem,
    output logic              div_by_zero
);

    logic              valid_reg;
    logic [DATA_W-1:0] quot_reg;
    logic [DATA_W-1:0] quot_next;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] rem_next;
    logic              dz_reg;
    logic [DATA_W-1:0] dz_quot;

    // Pick the final quotient and remainder
    always_comb begin
        if (in_stage.flags.nz) begin
            dz_quot = '0;
        end else if (!in_stage.flags.sgn) begin
            dz_quot = ALL_ONES;
        end else if (in_stage.flags.r_neg) begin
            dz_quot = NEG_LIMIT;
        end else begin
            dz_quot = POS_LIMIT;
        end

        if (in_stage.flags.dz) begin
            quot_next = dz_quot;
        end else if (in_stage.flags.q_neg) begin
            quot_next = ~in_stage.quo + DATA_W'(1);
        end else begin
            quot_next = in_stage.quo;
        end

        // Divide by zero leaves the numerator magnitude here, so this
        // sign fix returns the original numerator as well
        rem_next = in_stage.flags.r_neg ? (~in_stage.rem + DATA_W'(1)) : in_stage.rem;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
            dz_reg   <= in_stage.flags.dz;
        end
    end

    assign out_valid   = valid_reg;
    assign quot        = quot_reg;
    assign rem         = rem_reg;
    assign div_by_zero = dz_reg;

endmodule

// File: src/int32_divide_with_remainder.sv
// Pipelined 32-bit divider, unsigned (s_cmd = 0) or signed (s_cmd = 1), giving
// quotient, remainder and a divide-by-zero flag. One beat is accepted every
// cycle unless the output stalls. Each result passes one input stage, a chain
// of 32 cells that each settle one quotient bit, and one output register; the
// whole pipeline advances together and stops only while a finished result sits
// unread at the output. Signed division truncates toward zero and the remainder
// takes the numerator's sign. On a zero divisor the remainder is the numerator;
// the quotient is zero for a zero numerator, else all ones if unsigned or the
// limit of its sign if signed. Depends on idiv_pkg, idiv_pre, idiv_cell, idiv_post.
module int32_divide_with_remainder import idiv_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic [DATA_W-1:0] s_dividend,
    input  logic [DATA_W-1:0] s_divisor,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_quot,
    output logic [DATA_W-1:0] m_rem,
    output logic              m_div_by_zero
);

    logic       en;
    logic       chain_valid [DATA_W+1];
    div_stage_t chain_stage [DATA_W+1];

    // Advance everything unless the output beat is stalled
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    idiv_pre u_pre (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .cmd       (s_cmd),
        .dividend  (s_dividend),
        .divisor   (s_divisor),
        .out_valid (chain_valid[0]),
        .out_stage (chain_stage[0])
    );

    // One cell per quotient bit
    for (genvar i = 0; i < DATA_W; i++) begin : g_cell
        idiv_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_stage  (chain_stage[i]),
            .out_valid (chain_valid[i+1]),
            .out_stage (chain_stage[i+1])
        );
    end

    idiv_post u_post (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (chain_valid[DATA_W]),
        .in_stage    (chain_stage[DATA_W]),
        .out_valid   (m_valid),
        .quot        (m_quot),
        .rem         (m_rem),
        .div_by_zero (m_div_by_zero)
    );

endmodule
